/* src/twl_pkg.sv */
// Package for the throttle window limiter: constants, microcode types and the control store.
`default_nettype none
package twl_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_RPM       = 3'd0,
		REG_RPM_DIVISOR   = 3'd1,
		REG_LAUNCH_VALUE  = 3'd2,
		REG_WINDOW_MARGIN = 3'd3,
		REG_MIN_CELL_MV   = 3'd4
	} cfg_reg_t;

	localparam logic [15:0] MAX_RPM_RST       = 16'd5000;
	localparam logic [9:0]  RPM_DIVISOR_RST   = 10'd106;
	localparam logic [7:0]  LAUNCH_VALUE_RST  = 8'd30;
	localparam logic [6:0]  WINDOW_MARGIN_RST = 7'd40;
	localparam logic [15:0] MIN_CELL_MV_RST   = 16'd3300;

	// datapath constants, Q8.8 where fractional
	localparam logic [15:0] PACK_LOW_MV   = 16'd44000;
	localparam logic [15:0] KV_CAP        = 16'd10240;   // 40.0
	localparam logic [15:0] LOW_SPEED_RPM = 16'd2000;
	localparam logic [6:0]  PCT_TIER0     = 7'd85;
	localparam logic [6:0]  PCT_TIER1     = 7'd90;
	localparam logic [6:0]  PCT_TIER2     = 7'd95;
	localparam logic [16:0] TIER_STEP_MV  = 17'd100;
	localparam logic [7:0]  HOT_TEMP      = 8'd120;
	localparam logic [7:0]  STANDSTILL_THR = 8'd20;
	localparam logic [15:0] FULL_Q        = 16'd65280;   // 255.0

	// constant divisions as floor(x * M / 2^k), exact over the operand ranges used
	localparam logic [23:0] SLOPE_RECIP = 24'd16492675;  // speed*6144/3125, k = 23
	localparam logic [23:0] PCT_RECIP   = 24'd10737419;  // x/100, k = 30
	localparam logic [15:0] HOT_RECIP   = 16'd52429;     // x/5, k = 18

	// divider: 24-bit dividend, 12-bit divisor, two quotient bits a cycle
	localparam int DIV_NUM_W = 24;
	localparam int DIV_DEN_W = 12;
	localparam logic [3:0] DIV_CYC_24 = 4'd12;

	typedef logic [3:0] step_t;

	typedef enum logic [3:0] {
		UOP_NOP,
		UOP_LATCH,
		UOP_KV_LOAD,
		UOP_DIV_STEP,
		UOP_KV_DONE,
		UOP_GAS_LOAD,
		UOP_GAS_DONE,
		UOP_CELL_LOAD,
		UOP_CELL_DONE,
		UOP_HOT_DONE,
		UOP_FIX_BASE,
		UOP_FINISH
	} uop_t;

	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_INPUT,
		C_DIV_MORE,
		C_FAST,
		C_NO_TIER,
		C_NOT_HOT,
		C_OUT_FREE
	} cond_t;

	typedef struct packed {
		uop_t  op;
		cond_t cond;
		step_t target;
	} ucw_t;

	localparam step_t STEP_IDLE = 4'd0;

	// control store: taken jump goes to target, otherwise to the next step
	function automatic ucw_t ucode_rom(input step_t step);
		ucw_t w;
		unique case (step)
			4'd0:    w = '{UOP_LATCH,     C_NO_INPUT, 4'd0};
			4'd1:    w = '{UOP_KV_LOAD,   C_NEVER,    4'd0};
			4'd2:    w = '{UOP_DIV_STEP,  C_DIV_MORE, 4'd2};
			4'd3:    w = '{UOP_KV_DONE,   C_FAST,     4'd6};
			4'd4:    w = '{UOP_GAS_LOAD,  C_NEVER,    4'd0};
			4'd5:    w = '{UOP_GAS_DONE,  C_NEVER,    4'd0};
			4'd6:    w = '{UOP_CELL_LOAD, C_NO_TIER,  4'd8};
			4'd7:    w = '{UOP_CELL_DONE, C_NEVER,    4'd0};
			4'd8:    w = '{UOP_NOP,       C_NOT_HOT,  4'd10};
			4'd9:    w = '{UOP_HOT_DONE,  C_NEVER,    4'd0};
			4'd10:   w = '{UOP_FIX_BASE,  C_NEVER,    4'd0};
			4'd11:   w = '{UOP_FINISH,    C_OUT_FREE, STEP_IDLE};
			default: w = '{UOP_NOP,       C_ALWAYS,   4'd11};
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

/* src/twl_if.sv */
// Sample and result channel interfaces of the throttle window limiter.
`default_nettype none
interface twl_sample_if;
	logic        valid;
	logic        ready;
	logic [7:0]  throttle;
	logic [15:0] speed_rpm;
	logic [15:0] pack_mv;
	logic [15:0] lowest_cell_mv;
	logic [7:0]  temperature;

	modport source (output valid, output throttle, output speed_rpm, output pack_mv,
		output lowest_cell_mv, output temperature, input ready);
	modport sink (input valid, input throttle, input speed_rpm, input pack_mv,
		input lowest_cell_mv, input temperature, output ready);
endinterface

interface twl_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] drive_value;
	logic [1:0] band;
	logic       over_limit;

	modport source (output valid, output drive_value, output band, output over_limit,
		input ready);
	modport sink (input valid, input drive_value, input band, input over_limit,
		output ready);
endinterface
`default_nettype wire

/* src/throttle_window_limiter_core.sv */
// Throttle window limiter: microcoded sequencer, serial speed divider, reciprocal multiplies.
// The sequencer accepts a sample, runs the speed quotient through the serial divider, then adds
// the low-speed gas slope, cell derating and heat derating, each only where it applies.
// Samples: one in work at a time; the next is accepted the cycle after the result is
// registered; a result waiting for ready holds the sequencer.
// Reset: arst_n clears the step counter, indicator and result valid, loads register defaults.
`default_nettype none
module throttle_window_limiter_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [twl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [twl_pkg::CFG_DATA_W-1:0]     cfg_data,
	twl_sample_if.sink                         sample,
	twl_result_if.source                       result
);
	import twl_pkg::*;

	// configuration
	logic [15:0] max_rpm_q;
	logic [9:0]  rpm_div_q;
	logic [7:0]  launch_q;
	logic [6:0]  margin_q;
	logic [15:0] min_cell_q;

	// sequencer
	step_t step_q, step_d;
	ucw_t  cw;
	logic  cond_true;
	logic  accept;

	// datapath
	logic [7:0]  thr_q;
	logic [15:0] spd_q;
	logic [15:0] pack_q;
	logic [15:0] cell_q;
	logic [7:0]  temp_q;
	logic [7:0]  base_q;
	logic [15:0] gas_q;
	logic        over_q;

	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [3:0]           cnt_q;

	logic        out_valid_q;
	logic [7:0]  drive_q;
	logic [1:0]  band_q;
	logic        over_lim_q;

	// ---------------- configuration writes ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_rpm_q  <= MAX_RPM_RST;
			rpm_div_q  <= RPM_DIVISOR_RST;
			launch_q   <= LAUNCH_VALUE_RST;
			margin_q   <= WINDOW_MARGIN_RST;
			min_cell_q <= MIN_CELL_MV_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_RPM:       max_rpm_q  <= cfg_data;
				REG_RPM_DIVISOR:   rpm_div_q  <= cfg_data[9:0];
				REG_LAUNCH_VALUE:  launch_q   <= cfg_data[7:0];
				REG_WINDOW_MARGIN: margin_q   <= cfg_data[6:0];
				REG_MIN_CELL_MV:   min_cell_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------- divider core, two bits a cycle ----------------
	logic [DIV_DEN_W:0]   r1, r2;
	logic                 ge1, ge2;
	logic [DIV_DEN_W-1:0] rem1, rem2;
	logic [DIV_NUM_W-1:0] n1, n2;

	always_comb begin
		r1   = {rem_q, num_q[DIV_NUM_W-1]};
		ge1  = r1 >= {1'b0, den_q};
		rem1 = ge1 ? DIV_DEN_W'(r1 - {1'b0, den_q}) : r1[DIV_DEN_W-1:0];
		n1   = {num_q[DIV_NUM_W-2:0], ge1};
		r2   = {rem1, n1[DIV_NUM_W-1]};
		ge2  = r2 >= {1'b0, den_q};
		rem2 = ge2 ? DIV_DEN_W'(r2 - {1'b0, den_q}) : r2[DIV_DEN_W-1:0];
		n2   = {n1[DIV_NUM_W-2:0], ge2};
	end

	// ---------------- datapath helpers ----------------
	logic [15:0] spd_clamped;
	logic [15:0] kv_sat, kv_cap;
	logic [18:0] kv5;
	logic [7:0]  base_sat;
	logic [34:0] slope_prod;
	logic [46:0] cell_prod;
	logic [31:0] hot_prod;
	logic [16:0] gas_sum;
	logic [16:0] tier1_lim, tier2_lim;
	logic        no_tier;
	logic [6:0]  pct;
	logic [22:0] derate_prod;
	logic [16:0] top_sum;
	logic [15:0] headroom;
	logic [7:0]  base_fixed;
	logic [8:0]  upper;
	logic [8:0]  thr_lo;
	logic [7:0]  drive_d;
	logic [1:0]  band_d;
	logic        over_d;

	assign spd_clamped = (sample.speed_rpm >= max_rpm_q) ? max_rpm_q : sample.speed_rpm;

	always_comb begin
		kv_sat = (num_q[23:16] != 8'd0) ? 16'hFFFF : num_q[15:0];
		kv_cap = (kv_sat >= KV_CAP && pack_q <= PACK_LOW_MV) ? KV_CAP : kv_sat;
		kv5 = {3'd0, kv_cap} + {1'b0, kv_cap, 2'b00};
		base_sat = (kv5[18:16] != 3'd0) ? 8'hFF : kv5[15:8];
	end

	// speed is at most 2000 on the low-speed path, so 11 bits carry it
	assign slope_prod = {24'd0, spd_q[10:0]} * {11'd0, SLOPE_RECIP};
	assign cell_prod  = {24'd0, num_q[22:0]} * {23'd0, PCT_RECIP};
	assign hot_prod   = {16'd0, gas_q} * {16'd0, HOT_RECIP};
	assign gas_sum    = {1'b0, launch_q, 8'd0} + {1'b0, num_q[15:0]};

	always_comb begin
		tier1_lim = {1'b0, min_cell_q} + TIER_STEP_MV;
		tier2_lim = tier1_lim + TIER_STEP_MV;
		no_tier   = 1'b0;
		if (cell_q <= min_cell_q)
			pct = PCT_TIER0;
		else if ({1'b0, cell_q} <= tier1_lim)
			pct = PCT_TIER1;
		else if ({1'b0, cell_q} <= tier2_lim)
			pct = PCT_TIER2;
		else begin
			pct     = PCT_TIER2;
			no_tier = 1'b1;
		end
		derate_prod = {7'd0, gas_q} * {16'd0, pct};
	end

	// base pulled down so base + gas stays at or below full scale, else raised to the window margin if not above it
	always_comb begin
		top_sum  = {1'b0, base_q, 8'd0} + {1'b0, gas_q};
		headroom = FULL_Q - gas_q;
		if (top_sum >= {1'b0, FULL_Q})
			base_fixed = (gas_q >= FULL_Q) ? 8'd0 : headroom[15:8];
		else if (base_q <= {1'b0, margin_q})
			base_fixed = {1'b0, margin_q};
		else
			base_fixed = base_q;
	end

	always_comb begin
		upper  = {1'b0, base_q} + {1'b0, gas_q[15:8]};
		thr_lo = {1'b0, thr_q} + {2'd0, margin_q};
		over_d = over_q;
		if (spd_q == 16'd0 && thr_q > STANDSTILL_THR) begin
			drive_d = launch_q;
			band_d  = 2'd0;
		end else if ({1'b0, thr_q} > upper) begin
			drive_d = upper[8] ? 8'hFF : upper[7:0];
			band_d  = 2'd1;
			over_d  = 1'b1;
		end else if (thr_lo < {1'b0, base_q}) begin
			drive_d = base_q - {1'b0, margin_q};
			band_d  = 2'd2;
		end else begin
			drive_d = thr_q;
			band_d  = 2'd3;
			over_d  = 1'b0;
		end
	end

	// ---------------- sequencer ----------------
	assign sample.ready = (step_q == STEP_IDLE);
	assign accept       = sample.valid && sample.ready;
	assign cw           = ucode_rom(step_q);

	always_comb begin
		unique case (cw.cond)
			C_NEVER:    cond_true = 1'b0;
			C_ALWAYS:   cond_true = 1'b1;
			C_NO_INPUT: cond_true = !accept;
			C_DIV_MORE: cond_true = (cnt_q != 4'd1);
			C_FAST:     cond_true = (spd_q > LOW_SPEED_RPM);
			C_NO_TIER:  cond_true = no_tier;
			C_NOT_HOT:  cond_true = (temp_q < HOT_TEMP);
			C_OUT_FREE: cond_true = !out_valid_q || result.ready;
			default:    cond_true = 1'b0;
		endcase
		step_d = cond_true ? cw.target : step_t'(step_q + 4'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_q <= STEP_IDLE;
		else
			step_q <= step_d;
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		case (cw.op)
			UOP_LATCH: begin
				if (accept) begin
					thr_q  <= sample.throttle;
					spd_q  <= spd_clamped;
					pack_q <= sample.pack_mv;
					cell_q <= sample.lowest_cell_mv;
					temp_q <= sample.temperature;
				end
			end
			UOP_KV_LOAD: begin
				num_q <= {spd_q, 8'd0};
				den_q <= {2'd0, (rpm_div_q == 10'd0) ? 10'd1 : rpm_div_q};
				rem_q <= '0;
				cnt_q <= DIV_CYC_24;
			end
			UOP_DIV_STEP: begin
				num_q <= n2;
				rem_q <= rem2;
				cnt_q <= cnt_q - 4'd1;
			end
			UOP_KV_DONE: begin
				base_q <= base_sat;
				gas_q  <= {1'b0, margin_q, 8'd0};
			end
			UOP_GAS_LOAD:  num_q <= {12'd0, slope_prod[34:23]};
			UOP_GAS_DONE:  gas_q <= gas_sum[16] ? 16'hFFFF : gas_sum[15:0];
			UOP_CELL_LOAD: num_q <= {1'b0, derate_prod};
			UOP_CELL_DONE: gas_q <= cell_prod[45:30];
			UOP_HOT_DONE:  gas_q <= {2'd0, hot_prod[31:18]};
			UOP_FIX_BASE:  base_q <= base_fixed;
			default: ;
		endcase
	end

	// ---------------- indicator and result register ----------------
	logic finish_fire;
	assign finish_fire = (cw.op == UOP_FINISH) && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			over_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (finish_fire) begin
				over_q      <= over_d;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish_fire) begin
			drive_q    <= drive_d;
			band_q     <= band_d;
			over_lim_q <= over_d;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.drive_value = drive_q;
	assign result.band        = band_q;
	assign result.over_limit  = over_lim_q;

endmodule
`default_nettype wire

/* src/twl_checker.sv */
// Port-level checks for the throttle window limiter, bound to the top level.
`default_nettype none
module twl_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] out_band,
	input logic       out_over
);

	// one sample in flight: the sample side closes right after a transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("sample accepted while previous one still in work");

	a_over_on_clip_high: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_band == 2'd1 |-> out_over)
		else $error("clipped high without over-limit");

	a_over_clear_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_band == 2'd3 |-> !out_over)
		else $error("within window but over-limit set");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transaction");

endmodule

bind throttle_window_limiter_core twl_checker u_twl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample.valid),
	.in_ready  (sample.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_band  (result.band),
	.out_over  (result.over_limit)
);
`default_nettype wire
